[design/sbme_pkg.sv]
// sbme_pkg: shared types, register indexes and arithmetic constants of the
// skeleton bone matrix engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbme_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TBL,
    ST_LOAD,
    ST_PHASE,
    ST_SINE,
    ST_MAT,
    ST_TRANS,
    ST_SCALE,
    ST_EMIT
  } state_t;

  // configuration register indexes
  localparam logic [2:0] CFG_MIRROR_MODE = 3'd0;
  localparam logic [2:0] CFG_WORLD_SCALE = 3'd1;
  localparam logic [2:0] CFG_WORLD_YAW   = 3'd2;
  localparam logic [2:0] CFG_WORLD_POS_X = 3'd3;
  localparam logic [2:0] CFG_WORLD_POS_Y = 3'd4;
  localparam logic [2:0] CFG_WORLD_POS_Z = 3'd5;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_POSE = 1'b1;

  localparam logic [1:0] ROW_TRANS = 2'd3;

  localparam logic [24:0] SCALE_RESET = 25'd65536;

  // radians Q3.13 to phase in 1/65536 turn
  localparam logic signed [25:0] PHASE_MUL = 26'sd83443;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // quarter-wave sine polynomial coefficients (unsigned Q1.14)
  localparam logic [14:0] SIN_C0 = 15'd25736;
  localparam logic [14:0] SIN_C1 = 15'd10583;
  localparam logic [14:0] SIN_C2 = 15'd1231;
  localparam logic [14:0] SIN_ONE = 15'd16384;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7fff;
    else if (v < -18'sd32768) r = -16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[design/sbme_ram.sv]
// sbme_ram: generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sbme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/skeleton_bone_matrix_engine.sv]
// skeleton_bone_matrix_engine: top level. Skeleton tables in four sbme_ram
// instances, one shared multiplier sequenced by a state machine. Uses sbme_pkg.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  command   | start / busy       | cmd bone parent mirror_bone offset_* pitch yaw roll
//  result    | strobe (no stall)  | out_bone row x y z last
//  config    | cfg_we             | cfg_index cfg_data
//
// A load transaction writes the tables when it is accepted; busy never rises for it.
// A pose transaction keeps busy high while it runs: the table reads (ST_TBL,
// ST_LOAD), then all arithmetic through the one multiplier, one product per
// cycle (3 phase products, 4 per sine for six sines, 14 matrix products, 9 for
// the parent transform of a child bone, 3 scale products). The four rows leave
// while busy is still high, row 0 first. A new command is taken the cycle
// after row 3.
// rst is synchronous; it returns the sequencer to idle and the registers to
// their defaults. Table contents are not cleared. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module skeleton_bone_matrix_engine #(
  parameter int MAX_BONES = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cmd,
  input  wire logic [4:0]         bone,
  input  wire logic signed [5:0]  parent,
  input  wire logic [4:0]         mirror_bone,
  input  wire logic signed [31:0] offset_x,
  input  wire logic signed [31:0] offset_y,
  input  wire logic signed [31:0] offset_z,
  input  wire logic signed [15:0] pitch,
  input  wire logic signed [15:0] yaw,
  input  wire logic signed [15:0] roll,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    strobe,
  output logic [4:0]              out_bone,
  output logic [1:0]              row,
  output logic signed [31:0]      x,
  output logic signed [31:0]      y,
  output logic signed [31:0]      z,
  output logic                    last
);

  localparam int BW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

  // configuration registers
  logic               mirror_mode;
  logic [24:0]        world_scale;
  logic signed [15:0] world_yaw;
  logic signed [31:0] world_pos_x, world_pos_y, world_pos_z;

  sbme_pkg::state_t state, state_next;
  logic [3:0] cnt, cnt_next;
  logic [1:0] ci, ci_next, ki, ki_next;

  logic accept, bone_ok;

  // transaction registers
  logic [4:0]         bone_q;
  logic signed [17:0] ang [3];
  logic               par_ok, mb_ok;
  logic [15:0]        ph [3];
  logic signed [16:0] sn [6];
  logic [14:0]        sc_u, sc_t, sc_inner, sc_mid;
  logic signed [17:0] tmp [12];
  logic signed [31:0] off [3];
  logic signed [15:0] prot [9];
  logic signed [31:0] ptr [3];
  logic signed [49:0] acc;
  logic signed [31:0] tr [3];
  logic signed [31:0] ot [3];
  logic signed [15:0] rot_sat [9];

  // memory ports
  logic [10:0]  pm_rdata;
  logic [95:0]  off_rdata, tr_rdata;
  logic [143:0] rot_rdata, rot_wdata;
  logic [95:0]  tr_wdata;
  logic [BW-1:0] off_raddr, par_raddr;
  logic          pose_we;

  // shared multiplier
  logic signed [32:0] ma;
  logic signed [25:0] mb;
  logic signed [58:0] prod;

  // sine unit helpers
  logic [15:0] sphase;
  logic [14:0] su0;
  logic signed [17:0] mat_add, mat_res;
  logic [3:0]  mat_dst;
  logic [3:0]  rot_idx;
  logic signed [49:0] acc_sum;
  logic signed [31:0] wp;
  logic [3:0] row_base;

  assign busy    = (state != sbme_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign bone_ok = (32'(bone) < MAX_BONES);

  // ---------------------------------------------------------------- tables
  sbme_ram #(.WIDTH(11), .DEPTH(MAX_BONES)) u_pm_ram (
    .clk   (clk),
    .we    (accept && bone_ok && cmd == sbme_pkg::CMD_LOAD),
    .waddr (BW'(bone)),
    .wdata ({parent, mirror_bone}),
    .raddr (BW'(bone)),
    .rdata (pm_rdata)
  );

  sbme_ram #(.WIDTH(96), .DEPTH(MAX_BONES)) u_off_ram (
    .clk   (clk),
    .we    (accept && bone_ok && cmd == sbme_pkg::CMD_LOAD),
    .waddr (BW'(bone)),
    .wdata ({offset_z, offset_y, offset_x}),
    .raddr (off_raddr),
    .rdata (off_rdata)
  );

  sbme_ram #(.WIDTH(144), .DEPTH(MAX_BONES)) u_rot_ram (
    .clk   (clk),
    .we    (pose_we),
    .waddr (BW'(bone_q)),
    .wdata (rot_wdata),
    .raddr (par_raddr),
    .rdata (rot_rdata)
  );

  sbme_ram #(.WIDTH(96), .DEPTH(MAX_BONES)) u_tr_ram (
    .clk   (clk),
    .we    (pose_we),
    .waddr (BW'(bone_q)),
    .wdata (tr_wdata),
    .raddr (par_raddr),
    .rdata (tr_rdata)
  );

  // the mirror bone's offset in mirror mode, else the bone's own
  assign off_raddr = mirror_mode ? BW'(pm_rdata[4:0]) : BW'(bone_q);
  assign par_raddr = BW'(pm_rdata[10:5]);
  // write the new matrix as the first row leaves; parent reads are long done
  assign pose_we   = (state == sbme_pkg::ST_EMIT) && (cnt == 4'd0);

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rot_sat[i] = sbme_pkg::sat16(tmp[i]);
      rot_wdata[i*16 +: 16] = rot_sat[i];
    end
    for (int i = 0; i < 3; i++) begin
      tr_wdata[i*32 +: 32] = tr[i];
    end
  end

  // ---------------------------------------------------------- config port
  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_mode <= 1'b0;
      world_scale <= sbme_pkg::SCALE_RESET;
      world_yaw   <= '0;
      world_pos_x <= '0;
      world_pos_y <= '0;
      world_pos_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbme_pkg::CFG_MIRROR_MODE: mirror_mode <= cfg_data[0];
        sbme_pkg::CFG_WORLD_SCALE: world_scale <= cfg_data[24:0];
        sbme_pkg::CFG_WORLD_YAW:   world_yaw   <= cfg_data[15:0];
        sbme_pkg::CFG_WORLD_POS_X: world_pos_x <= cfg_data;
        sbme_pkg::CFG_WORLD_POS_Y: world_pos_y <= cfg_data;
        sbme_pkg::CFG_WORLD_POS_Z: world_pos_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------- operand select
  assign sphase = ph[cnt[2:1]] + (cnt[0] ? sbme_pkg::QUARTER_TURN : 16'd0);
  assign su0    = sphase[14] ? (sbme_pkg::SIN_ONE - {1'b0, sphase[13:0]})
                             : {1'b0, sphase[13:0]};
  assign rot_idx = 4'(ki) * 4'd3 + 4'(ci);

  always_comb begin
    ma      = '0;
    mb      = '0;
    mat_add = '0;
    mat_dst = '0;
    wp      = world_pos_x;
    unique case (state)
      sbme_pkg::ST_PHASE: begin
        ma = 33'(ang[cnt[1:0]]);
        mb = sbme_pkg::PHASE_MUL;
      end
      sbme_pkg::ST_SINE: begin
        unique case (ki)
          2'd0: begin ma = 33'(su0);  mb = 26'(su0); end
          2'd1: begin ma = 33'(sc_t); mb = 26'(sbme_pkg::SIN_C2); end
          2'd2: begin ma = 33'(sc_t); mb = 26'(sc_inner); end
          default: begin ma = 33'(sc_u); mb = 26'(sc_mid); end
        endcase
      end
      sbme_pkg::ST_MAT: begin
        // sx sn0, cx sn1, sy sn2, cy sn3, sz sn4, cz sn5; tmp9..11 cxcy sxcy sysz
        unique case (cnt)
          4'd0:  begin ma = 33'(sn[1]);   mb = 26'(sn[3]);  mat_dst = 4'd9;  end
          4'd1:  begin ma = 33'(sn[0]);   mb = 26'(sn[3]);  mat_dst = 4'd10; end
          4'd2:  begin ma = 33'(sn[2]);   mb = 26'(sn[4]);  mat_dst = 4'd11; end
          4'd3:  begin ma = 33'(sn[5]);   mb = 26'(sn[3]);  mat_dst = 4'd0;  end
          4'd4:  begin ma = 33'(sn[4]);   mb = 26'(sbme_pkg::SIN_ONE); mat_dst = 4'd1; end
          4'd5:  begin ma = -33'(sn[2]);  mb = 26'(sn[5]);  mat_dst = 4'd2;  end
          4'd6:  begin ma = -33'(sn[4]);  mb = 26'(tmp[9]); mat_dst = 4'd3;  end
          4'd7:  begin
            ma = 33'(sn[2]); mb = 26'(sn[0]); mat_add = tmp[3]; mat_dst = 4'd3;
          end
          4'd8:  begin ma = 33'(sn[5]);   mb = 26'(sn[1]);  mat_dst = 4'd4;  end
          4'd9:  begin ma = -33'(sn[5]);  mb = 26'(sn[0]);  mat_dst = 4'd5;  end
          4'd10: begin ma = 33'(sn[4]);   mb = 26'(tmp[10]); mat_dst = 4'd6; end
          4'd11: begin
            ma = 33'(sn[2]); mb = 26'(sn[1]); mat_add = tmp[6]; mat_dst = 4'd6;
          end
          4'd12: begin
            ma = 33'(tmp[11]); mb = 26'(sn[1]); mat_add = tmp[10]; mat_dst = 4'd7;
          end
          default: begin
            ma = -33'(tmp[11]); mb = 26'(sn[0]); mat_add = tmp[9]; mat_dst = 4'd8;
          end
        endcase
      end
      sbme_pkg::ST_TRANS: begin
        ma = 33'(off[ki]);
        mb = 26'(prot[rot_idx]);
      end
      sbme_pkg::ST_SCALE: begin
        ma = 33'(tr[cnt[1:0]]);
        mb = $signed({1'b0, world_scale});
        unique case (cnt[1:0])
          2'd0:    wp = world_pos_x;
          2'd1:    wp = world_pos_y;
          default: wp = world_pos_z;
        endcase
      end
      default: ;
    endcase
  end

  assign prod    = ma * mb;
  assign mat_res = 18'(prod >>> 14) + mat_add;
  assign acc_sum = acc + 50'(prod);

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbme_pkg::ST_IDLE;
      cnt   <= '0;
      ci    <= '0;
      ki    <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ci    <= ci_next;
      ki    <= ki_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ci_next    = ci;
    ki_next    = ki;
    unique case (state)
      sbme_pkg::ST_IDLE: begin
        if (accept && bone_ok && cmd == sbme_pkg::CMD_POSE) begin
          state_next = sbme_pkg::ST_TBL;
        end
      end
      sbme_pkg::ST_TBL:  state_next = sbme_pkg::ST_LOAD;
      sbme_pkg::ST_LOAD: begin
        state_next = sbme_pkg::ST_PHASE;
        cnt_next   = '0;
      end
      sbme_pkg::ST_PHASE: begin
        if (cnt == 4'd2) begin
          state_next = sbme_pkg::ST_SINE;
          cnt_next   = '0;
          ki_next    = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      sbme_pkg::ST_SINE: begin
        ki_next = ki + 2'd1;
        if (ki == 2'd3) begin
          if (cnt == 4'd5) begin
            state_next = sbme_pkg::ST_MAT;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + 4'd1;
          end
        end
      end
      sbme_pkg::ST_MAT: begin
        if (cnt == 4'd13) begin
          cnt_next = '0;
          ci_next  = '0;
          ki_next  = '0;
          state_next = par_ok ? sbme_pkg::ST_TRANS : sbme_pkg::ST_SCALE;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      sbme_pkg::ST_TRANS: begin
        if (ki == 2'd2) begin
          ki_next = '0;
          if (ci == 2'd2) begin
            state_next = sbme_pkg::ST_SCALE;
            cnt_next   = '0;
          end else begin
            ci_next = ci + 2'd1;
          end
        end else begin
          ki_next = ki + 2'd1;
        end
      end
      sbme_pkg::ST_SCALE: begin
        if (cnt == 4'd2) begin
          state_next = sbme_pkg::ST_EMIT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      sbme_pkg::ST_EMIT: begin
        if (cnt == 4'd3) begin
          state_next = sbme_pkg::ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 4'd1;
        end
      end
      default: state_next = sbme_pkg::ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    unique case (state)
      sbme_pkg::ST_IDLE: begin
        // capture angles; mirror mode flips yaw and roll, world yaw joins yaw
        bone_q <= bone;
        ang[0] <= 18'(pitch);
        if (mirror_mode) begin
          ang[1] <= -18'(yaw) + 18'(world_yaw);
          ang[2] <= -18'(roll);
        end else begin
          ang[1] <= 18'(yaw) + 18'(world_yaw);
          ang[2] <= 18'(roll);
        end
        acc <= '0;
      end
      sbme_pkg::ST_TBL: begin
        par_ok <= !pm_rdata[10] && (32'(pm_rdata[9:5]) < MAX_BONES);
        mb_ok  <= !mirror_mode || (32'(pm_rdata[4:0]) < MAX_BONES);
      end
      sbme_pkg::ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          off[i] <= mb_ok ? off_rdata[i*32 +: 32] : 32'sd0;
          tr[i]  <= mb_ok ? off_rdata[i*32 +: 32] : 32'sd0;
          ptr[i] <= tr_rdata[i*32 +: 32];
        end
        for (int i = 0; i < 9; i++) begin
          prot[i] <= rot_rdata[i*16 +: 16];
        end
      end
      sbme_pkg::ST_PHASE: begin
        ph[cnt[1:0]] <= prod[31:16];
      end
      sbme_pkg::ST_SINE: begin
        unique case (ki)
          2'd0: begin
            sc_u <= su0;
            sc_t <= 15'(prod >>> 14);
          end
          2'd1: sc_inner <= sbme_pkg::SIN_C1 - 15'(prod >>> 14);
          2'd2: sc_mid   <= sbme_pkg::SIN_C0 - 15'(prod >>> 14);
          default: begin
            sn[cnt[2:0]] <= sphase[15] ? -17'(prod >>> 14) : 17'(prod >>> 14);
          end
        endcase
      end
      sbme_pkg::ST_MAT: begin
        tmp[mat_dst] <= mat_res;
      end
      sbme_pkg::ST_TRANS: begin
        // accumulate one column, then round down and add the parent translation
        if (ki == 2'd2) begin
          tr[ci] <= sbme_pkg::sat32(64'(acc_sum >>> 14) + 64'(ptr[ci]));
          acc    <= '0;
        end else begin
          acc <= acc_sum;
        end
      end
      sbme_pkg::ST_SCALE: begin
        ot[cnt[1:0]] <= sbme_pkg::sat32(64'(prod >>> 16) + 64'(wp));
      end
      default: ;
    endcase
  end

  // -------------------------------------------------------------- results
  assign strobe   = (state == sbme_pkg::ST_EMIT);
  assign out_bone = bone_q;
  assign row      = cnt[1:0];
  assign last     = strobe && (row == sbme_pkg::ROW_TRANS);
  assign row_base = 4'(row) * 4'd3;

  always_comb begin
    if (row == sbme_pkg::ROW_TRANS) begin
      x = ot[0];
      y = ot[1];
      z = ot[2];
    end else begin
      // rotation rows leave as Q16.16: Q2.14 times four
      x = {{14{rot_sat[row_base][15]}}, rot_sat[row_base], 2'b00};
      y = {{14{rot_sat[row_base + 4'd1][15]}}, rot_sat[row_base + 4'd1], 2'b00};
      z = {{14{rot_sat[row_base + 4'd2][15]}}, rot_sat[row_base + 4'd2], 2'b00};
    end
  end

endmodule

`default_nettype wire

[design/sbme_checker.sv]
// sbme_assert: port-level assertions on the result stream, bound to
// skeleton_bone_matrix_engine. Uses sbme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbme_assert (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic       last,
  input wire logic [1:0] row,
  input wire logic [4:0] out_bone
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result shown while idle");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    last == (strobe && row == sbme_pkg::ROW_TRANS))
    else $error("last does not mark the translation row");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && row == $past(row) + 2'd1 &&
                        out_bone == $past(out_bone))
    else $error("rows of a bone out of order");

  a_first_row: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> row == 2'd0)
    else $error("bone does not start at row 0");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result right after the last row");

endmodule

bind skeleton_bone_matrix_engine sbme_assert u_sbme_assert (
  .clk      (clk),
  .rst      (rst),
  .busy     (busy),
  .strobe   (strobe),
  .last     (last),
  .row      (row),
  .out_bone (out_bone)
);

`default_nettype wire
